// File: rtl/core/stg_pkg.sv
`default_nettype none

package stg_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 2'd2;

  localparam logic [31:0] PHASE_INC_RST = 32'd973915487;
  localparam logic [14:0] AMPLITUDE_RST = 15'd16384;
  localparam logic [23:0] TOTAL_RST     = 24'd2646000;

  localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;

  // floor(a*b / 2^62), kept to 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  // floor(num / den) by restoring shift and subtract, den nonzero
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = 65'd0;
    quo = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(x) in Q62 for x in [0, pi/2], Taylor series in exact integers
  function automatic logic [63:0] sine_q62(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] div;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        div  = 64'((2 * n) * (2 * n + 1));
        term = udiv64(mul_q62(term, x2), div);
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    if (sum > ONE_Q62) begin
      sum = ONE_Q62;
    end
    return sum;
  endfunction

  // round(32767*sin(x)) for x in Q62
  function automatic logic [14:0] sine_rom_value(input logic [63:0] x);
    logic [127:0] p;
    logic [65:0]  v;
    p = 128'(sine_q62(x)) * 128'd32767 + (128'd1 << 61);
    v = p[127:62];
    if (v > 66'd32767) begin
      v = 66'd32767;
    end
    return v[14:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sine_tone_generator_with_fade.sv
// Sine tone generator with a linear fade-out at the end of each burst.
// Input channel (in_valid/in_ready, in_restart): one item asks for one PCM
// sample; in_restart = 1 clears phase and sample index before that sample.
// Result channel (out_valid/out_ready): out_sample (signed 16 bit), out_last
// on the final sample of a burst, out_fading when the fade factor applied.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 phase
// increment, 1 amplitude (Q0.15), 2 burst length; write only while idle.
// A single 32x32 multiplier is reused under a small sequencer: phase to table
// position, sine times amplitude, then for fading samples times remaining and
// a reciprocal divide by FADE_LENGTH with one correction step.
// A new item is accepted only in the idle state, so it waits until the previous
// item has left the sequencer; fading items pass through the extra divide steps.
// The sine table read is one registered memory access per item.
// The result sits in an output register, so the next item is accepted while
// it waits; a stalled receiver holds the finished item and the next result
// waits in the sequencer until the output register is free.
// Reset (synchronous, active low) clears phase and index, loads the default
// register values and leaves the output empty.
`default_nettype none

module sine_tone_generator_with_fade #(
  parameter int FADE_LENGTH      = 100,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             out_sample,
  output logic                           out_last,
  output logic                           out_fading,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import stg_pkg::*;

  localparam int RW = $clog2(FADE_LENGTH + 1);
  localparam int YW = 15 + RW;
  localparam logic [31:0] RecipM = 32'((64'd1 << YW) / FADE_LENGTH);
  localparam int PW = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [31:0] FourDepth = 32'(4 * SINE_TABLE_DEPTH);
  localparam logic [PW-1:0] Quad1 = PW'(SINE_TABLE_DEPTH);
  localparam logic [PW-1:0] Quad2 = PW'(2 * SINE_TABLE_DEPTH);
  localparam logic [PW-1:0] Quad3 = PW'(3 * SINE_TABLE_DEPTH);
  localparam logic [AW-1:0] DepthA = AW'(SINE_TABLE_DEPTH);
  localparam logic [63:0] PiStep    = PI_HALF_Q62 / SINE_TABLE_DEPTH;
  localparam logic [63:0] PiStepRem = PI_HALF_Q62 % SINE_TABLE_DEPTH;

  typedef logic [14:0] rom_arr_t [SINE_TABLE_DEPTH + 1];

  function automatic rom_arr_t build_rom();
    rom_arr_t    t;
    logic [63:0] x;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = PiStep * 64'(k) + udiv64(PiStepRem * 64'(k), 64'(SINE_TABLE_DEPTH));
      t[k] = sine_rom_value(x);
    end
    return t;
  endfunction

  localparam rom_arr_t SineRom = build_rom();

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_QUAD, S_ROM, S_AMP, S_SCALE, S_RECIP, S_CORR, S_FIX, S_FINISH
  } state_t;

  state_t        state_r;
  logic [31:0]   phase_inc_r;
  logic [14:0]   amplitude_r;
  logic [23:0]   total_r;
  logic [31:0]   phase_r;
  logic [23:0]   index_r;
  logic          last_r;
  logic          fading_r;
  logic [RW-1:0] rem_r;
  logic [63:0]   prod_r;
  logic [AW-1:0] rom_addr_r;
  logic          neg_r;
  logic [14:0]   rom_data_r;
  logic [YW-1:0] y_r;
  logic [14:0]   q_r;
  logic [14:0]   mag_r;
  logic          out_valid_r;
  logic signed [15:0] out_sample_r;
  logic          out_last_r;
  logic          out_fading_r;

  // Shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    unique case (state_r)
      S_POS: begin
        mul_a = phase_r;
        mul_b = FourDepth;
      end
      S_AMP: begin
        mul_a = 32'(rom_data_r);
        mul_b = 32'(amplitude_r);
      end
      S_SCALE: begin
        mul_a = 32'(prod_r[29:0]);
        mul_b = 32'(rem_r);
      end
      S_RECIP: begin
        mul_a = 32'(prod_r[15 +: YW]);
        mul_b = RecipM;
      end
      S_CORR: begin
        mul_a = 32'(prod_r[YW +: 15]);
        mul_b = 32'(FADE_LENGTH);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Burst position
  logic [23:0] burst_n;
  logic        is_last;
  logic [23:0] remaining;
  logic        is_fading;

  always_comb begin
    burst_n   = (total_r == 24'd0) ? 24'd1 : total_r;
    is_last   = (index_r >= burst_n - 24'd1);
    remaining = (index_r < burst_n) ? (burst_n - index_r) : 24'd1;
    is_fading = (remaining < 24'(FADE_LENGTH));
  end

  // Quadrant fold of the table position
  logic [PW-1:0] pos;
  logic [1:0]    quad;
  logic [PW-1:0] off;
  logic [AW-1:0] addr;

  always_comb begin
    pos = prod_r[32 +: PW];
    priority if (pos >= Quad3) begin
      quad = 2'd3;
      off  = pos - Quad3;
    end else if (pos >= Quad2) begin
      quad = 2'd2;
      off  = pos - Quad2;
    end else if (pos >= Quad1) begin
      quad = 2'd1;
      off  = pos - Quad1;
    end else begin
      quad = 2'd0;
      off  = pos;
    end
    addr = quad[0] ? (DepthA - AW'(off)) : AW'(off);
  end

  // Correction step of the reciprocal divide
  logic [YW-1:0] div_rem;
  logic          div_fix;

  assign div_rem = y_r - prod_r[YW-1:0];
  assign div_fix = (div_rem >= YW'(FADE_LENGTH));

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    rom_data_r <= SineRom[rom_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_inc_r  <= PHASE_INC_RST;
      amplitude_r  <= AMPLITUDE_RST;
      total_r      <= TOTAL_RST;
      phase_r      <= 32'd0;
      index_r      <= 24'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_PHASE_INC: phase_inc_r <= cfg_data;
          CFG_AMPLITUDE: amplitude_r <= cfg_data[14:0];
          CFG_TOTAL:     total_r     <= cfg_data[23:0];
          default: ;
        endcase
      end

      // drop the taken result unless a new one replaces it this cycle
      if (out_valid_r && out_ready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_restart) begin
              phase_r <= 32'd0;
              index_r <= 24'd0;
            end
            state_r <= S_POS;
          end
        end
        S_POS: begin
          prod_r   <= mul_p;
          last_r   <= is_last;
          fading_r <= is_fading;
          rem_r    <= remaining[RW-1:0];
          state_r  <= S_QUAD;
        end
        S_QUAD: begin
          rom_addr_r <= addr;
          neg_r      <= quad[1];
          state_r    <= S_ROM;
        end
        S_ROM: begin
          state_r <= S_AMP;
        end
        S_AMP: begin
          prod_r  <= mul_p;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          if (fading_r) begin
            prod_r  <= mul_p;
            state_r <= S_RECIP;
          end else begin
            mag_r   <= prod_r[29:15];
            state_r <= S_FINISH;
          end
        end
        S_RECIP: begin
          y_r     <= prod_r[15 +: YW];
          prod_r  <= mul_p;
          state_r <= S_CORR;
        end
        S_CORR: begin
          q_r     <= prod_r[YW +: 15];
          prod_r  <= mul_p;
          state_r <= S_FIX;
        end
        S_FIX: begin
          mag_r   <= q_r + 15'(div_fix);
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
            out_last_r   <= last_r;
            out_fading_r <= fading_r;
            if (last_r) begin
              phase_r <= 32'd0;
              index_r <= 24'd0;
            end else begin
              phase_r <= phase_r + phase_inc_r;
              index_r <= index_r + 24'd1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;
  assign out_fading = out_fading_r;

endmodule

`default_nettype wire

// File: rtl/core/stg_checker.sv
`default_nettype none

module stg_checker #(
  parameter int FADE_LENGTH = 100
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_sample,
  input logic               out_last,
  input logic               out_fading
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample)
      && $stable(out_last) && $stable(out_fading))
    else $error("stalled result changed");

  // each accepted item leaves the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // a new result only comes out of a busy period
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a preceding item");

  // the final sample always has one step left, so fading applies when the fade is longer
  a_last_fades: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && (FADE_LENGTH > 1) |-> out_fading)
    else $error("final sample not faded");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sine_tone_generator_with_fade stg_checker #(.FADE_LENGTH(FADE_LENGTH)) u_stg_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stg_pkg::*;

  localparam int FADE_LEN    = 100;
  localparam int TABLE_DEPTH = 1024;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind it

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               fading;
  } tone_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [15:0]    out_sample;
  logic                  out_last;
  logic                  out_fading;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PHASE_INC;
  logic [31:0]           cfg_data = 32'd0;

  sine_tone_generator_with_fade dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .out_last   (out_last),
    .out_fading (out_fading),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Tone model: quarter-wave table, accumulator state and register copies
  logic [15:0] sine_tbl [0:TABLE_DEPTH];
  logic [31:0] tone_phase = 32'd0;
  logic [23:0] tone_index = 24'd0;
  logic [31:0] m_phase_inc = PHASE_INC_RST;
  logic [14:0] m_amplitude = AMPLITUDE_RST;
  logic [23:0] m_total = TOTAL_RST;

  logic         pending_restart [$];
  tone_result_t expected_tones [$];

  int n_samples   = 0;
  int n_last      = 0;
  int n_fading    = 0;
  int n_cfg       = 0;
  int n_mismatch  = 0;
  int burst_left  = 1;
  int gap_left    = 0;
  int ready_hold  = 0;

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // round(32767*sin(pi/2*k/TABLE_DEPTH)) from an integer Taylor series in Q62
  function automatic logic [15:0] table_entry(input int k);
    logic [63:0]  q;
    logic [63:0]  r;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] p;
    q    = PI_HALF_Q62 / 64'(TABLE_DEPTH);
    r    = PI_HALF_Q62 % 64'(TABLE_DEPTH);
    x    = q * 64'(k) + (r * 64'(k)) / 64'(TABLE_DEPTH);
    x2   = q62_mul(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 40 && term != 64'd0; n++) begin
      term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > ONE_Q62) begin
      sum = ONE_Q62;
    end
    p = {64'd0, sum} * 128'd32767 + (128'd1 << 61);
    p = p >> 62;
    if (p > 128'd32767) begin
      p = 128'd32767;
    end
    return p[15:0];
  endfunction

  function automatic tone_result_t next_tone(input logic restart);
    tone_result_t res;
    logic [31:0]  n;
    logic [31:0]  idx;
    logic [31:0]  rem;
    logic [11:0]  pos;
    logic [63:0]  mag;
    if (restart) begin
      tone_phase = 32'd0;
      tone_index = 24'd0;
    end
    n   = (m_total == 24'd0) ? 32'd1 : {8'd0, m_total};
    idx = {8'd0, tone_index};
    res.last = (idx >= n - 32'd1);
    if (idx < n) begin
      rem = n - idx;
    end else begin
      rem = 32'd1;
    end
    res.fading = (rem < FADE_LEN);
    pos = tone_phase[31:20];
    if (pos[10]) begin
      mag = {48'd0, sine_tbl[TABLE_DEPTH - pos[9:0]]};
    end else begin
      mag = {48'd0, sine_tbl[pos[9:0]]};
    end
    mag = mag * {49'd0, m_amplitude};
    if (res.fading) begin
      mag = (mag * {32'd0, rem}) / (64'd32768 * FADE_LEN);
    end else begin
      mag = mag >> 15;
    end
    res.sample = pos[11] ? (16'd0 - mag[15:0]) : mag[15:0];
    if (res.last) begin
      tone_phase = 32'd0;
      tone_index = 24'd0;
    end else begin
      tone_phase = tone_phase + m_phase_inc;
      tone_index = tone_index + 24'd1;
    end
    return res;
  endfunction

  // Sender: bursts of items with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_tones.push_back(next_tone(in_restart));
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_restart.size() != 0) begin
          in_valid   <= 1'b1;
          in_restart <= pending_restart.pop_front();
          if (burst_left <= 1) begin
            burst_left = int'($urandom_range(1, 12));
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 15));
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result against the oldest prediction, stall on its own pattern
  always @(posedge clk) begin
    tone_result_t want;
    logic         ready_next;
    ready_next = out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tones.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("unexpected result: sample %0d last %0b fading %0b",
                   out_sample, out_last, out_fading);
        end
      end else begin
        want = expected_tones.pop_front();
        n_samples++;
        if (want.last) n_last++;
        if (want.fading) n_fading++;
        if (out_sample !== want.sample || out_last !== want.last ||
            out_fading !== want.fading) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch on sample %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     n_samples, want.sample, want.last, want.fading,
                     out_sample, out_last, out_fading);
          end
        end
      end
    end
    if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          ready_next = 1'b1;
          ready_hold = $urandom_range(1, 40);
        end
        1: begin
          ready_next = 1'b0;
          ready_hold = $urandom_range(1, 20);
        end
        default: begin
          ready_next = 1'($urandom_range(0, 1));
          ready_hold = 0;
        end
      endcase
    end
    out_ready <= ready_next;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      CFG_PHASE_INC: m_phase_inc = data;
      CFG_AMPLITUDE: m_amplitude = data[14:0];
      CFG_TOTAL:     m_total     = data[23:0];
      default:       ;
    endcase
  endtask

  // Hold until every queued item is in and every result is out, then let the pipe drain
  task automatic wait_idle();
    while (pending_restart.size() != 0 || in_valid || expected_tones.size() != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic queue_items(input int count, input int restart_pct);
    for (int i = 0; i < count; i++) begin
      pending_restart.push_back($urandom_range(0, 99) < restart_pct);
    end
  endtask

  initial begin
    int random_items;
    int sel;
    for (int k = 0; k <= TABLE_DEPTH; k++) begin
      sine_tbl[k] = table_entry(k);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults, restart on the second item
    pending_restart.push_back(1'b0);
    pending_restart.push_back(1'b1);
    pending_restart.push_back(1'b0);
    wait_idle();

    // quarter-period steps at full amplitude through a short faded burst and its wrap
    write_reg(CFG_PHASE_INC, 32'h4000_0000);
    write_reg(CFG_AMPLITUDE, {17'h1ABCD, 15'h7FFF});
    write_reg(CFG_TOTAL, 32'd5);
    queue_items(6, 0);
    wait_idle();

    // zero amplitude, zero burst length taken as one, spare index dropped
    write_reg(CFG_AMPLITUDE, 32'd0);
    write_reg(CFG_TOTAL, 32'hFF00_0000);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    queue_items(2, 0);
    wait_idle();

    // burst length lowered below the current index
    write_reg(CFG_PHASE_INC, 32'h0123_4567);
    write_reg(CFG_AMPLITUDE, 32'd20000);
    write_reg(CFG_TOTAL, 32'd300);
    queue_items(8, 0);
    wait_idle();
    write_reg(CFG_TOTAL, 32'd3);
    queue_items(3, 0);
    wait_idle();

    random_items = 0;
    while (random_items < 500) begin
      if ($urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 5);
        case (sel)
          0:       write_reg(CFG_PHASE_INC, 32'd0);
          1:       write_reg(CFG_PHASE_INC, 32'h8000_0000);
          2:       write_reg(CFG_PHASE_INC, $urandom);
          3:       write_reg(CFG_PHASE_INC, $urandom_range(1, 32'h0010_0000));
          default: write_reg(CFG_PHASE_INC, $urandom_range(0, 32'h8000_0000));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 3);
        case (sel)
          0:       write_reg(CFG_AMPLITUDE, {17'($urandom_range(0, 131071)), 15'd0});
          1:       write_reg(CFG_AMPLITUDE, 32'd32767);
          default: write_reg(CFG_AMPLITUDE, {17'($urandom_range(0, 131071)),
                                             15'($urandom_range(0, 32767))});
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 5);
        case (sel)
          0:       write_reg(CFG_TOTAL, 32'd1);
          1:       write_reg(CFG_TOTAL, 32'h00FF_FFFF);
          2:       write_reg(CFG_TOTAL, $urandom_range(95, 105));
          3:       write_reg(CFG_TOTAL, $urandom_range(2, 40));
          default: write_reg(CFG_TOTAL, {8'($urandom), 24'($urandom_range(1, 200))});
        endcase
      end
      sel = $urandom_range(30, 60);
      queue_items(sel, 4);
      random_items += sel;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Checked %0d samples: %0d burst ends, %0d faded, %0d register writes",
             n_samples, n_last, n_fading, n_cfg);
    if (n_mismatch == 0 && expected_tones.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, expected_tones.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", expected_tones.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/stg_pkg.sv
rtl/core/sine_tone_generator_with_fade.sv
rtl/core/stg_checker.sv
tb/testbench.sv
